/* rtl/seven_segment_text_scan_driver_core_macros.svh */
// assertion macros of the port-level checker file
// depends on: a clock named clock and an active-high reset named reset in scope
`ifndef SEVEN_SEGMENT_TEXT_SCAN_DRIVER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_TEXT_SCAN_DRIVER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SSD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ssd_pkg.sv */
// shared types, constants and the glyph lookup of the seven-segment text scan driver
// depends on: nothing
package ssd_pkg;

   // item kind carried on tuser
   typedef enum logic {
      OP_CHAR = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   // one input word after unpacking
   typedef struct packed {
      opcode_type opcode;
      logic [7:0] char_code;
      logic       last_char;
   } req_item_type;

   // one result word, digit_select in the low byte
   typedef struct packed {
      logic [7:0] segment_code;
      logic [7:0] digit_select;
   } rsp_item_type;

   localparam logic [7:0] BLANK_CODE  = 8'hff;
   localparam logic [7:0] POINT_CLEAR = 8'h7f;
   localparam logic [7:0] DASH_CODE   = 8'hbf;
   localparam logic [7:0] DOT_CHAR    = 8'h2e;

   // active-low glyphs for 0-9 and A b C d E F
   localparam logic [7:0] GLYPH_TABLE [16] = '{
      8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
      8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e
   };

   // ascii character to active-low segment code, blank if no glyph
   function automatic logic [7:0] char_to_code(input logic [7:0] c);
      logic [7:0] code;
      code = BLANK_CODE;
      if (c >= 8'h30 && c <= 8'h39) begin
         code = GLYPH_TABLE[c[3:0]];
      end else begin
         unique case (c)
            8'h41:   code = GLYPH_TABLE[10];
            8'h62:   code = GLYPH_TABLE[11];
            8'h43:   code = GLYPH_TABLE[12];
            8'h64:   code = GLYPH_TABLE[13];
            8'h45:   code = GLYPH_TABLE[14];
            8'h46:   code = GLYPH_TABLE[15];
            8'h2d:   code = DASH_CODE;
            default: code = BLANK_CODE;
         endcase
      end
      return code;
   endfunction

endpackage

/* rtl/ssd_in_reg.sv */
// input register stage: holds one accepted word until the engine takes it
// depends on: ssd_pkg
module ssd_in_reg import ssd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  req_item_type req_item,
   input  logic         out_free,
   output logic         fire,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         accept;

   // a char word never waits, a tick waits for room in the result register
   assign fire       = valid_ff && ((item_ff.opcode == OP_CHAR) || out_free);
   assign req_tready = !valid_ff || fire;
   assign accept     = req_tvalid && req_tready;
   assign item       = item_ff;

   // next state
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

/* rtl/ssd_engine.sv */
// frame buffer, held character and scan pointer; builds the result of a tick
// depends on: ssd_pkg
module ssd_engine import ssd_pkg::*; #(
   parameter int NUM_DIGITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   localparam int SCAN_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int POS_W  = $clog2(NUM_DIGITS + 1);
   localparam logic [POS_W-1:0]  POS_LIMIT = POS_W'(NUM_DIGITS);
   localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(NUM_DIGITS - 1);

   logic [7:0]            codes_ff [NUM_DIGITS];
   logic [7:0]            codes_in [NUM_DIGITS];
   logic [NUM_DIGITS-1:0] shown_ff, shown_in;
   logic [SCAN_W-1:0]     scan_ff, scan_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [7:0]            held_code_ff, held_code_in;
   logic                  held_valid_ff, held_valid_in;
   logic                  held_point_ff, held_point_in;

   logic                  take_point;
   logic                  commit_a;
   logic                  commit_b;
   logic [POS_W-1:0]      pos_b;
   logic [7:0]            new_code;
   logic [NUM_DIGITS-1:0] shown_base;

   // tick result: one-hot select of the scanned digit (none past digit 7) and its code
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         result.digit_select[k] = (k < NUM_DIGITS) && (scan_ff == SCAN_W'(k));
      end
      result.segment_code = shown_ff[scan_ff] ? codes_ff[scan_ff] : BLANK_CODE;
   end

   // character decode: a dot attaches to the held digit once, anything else
   // pushes the held digit out and becomes the new held digit
   always_comb begin
      take_point = (item.char_code == DOT_CHAR) && held_valid_ff && !held_point_ff;
      commit_a   = !take_point && held_valid_ff && (pos_ff < POS_LIMIT);
      pos_b      = pos_ff + POS_W'(commit_a);
      new_code   = take_point ? (held_code_ff & POINT_CLEAR) : char_to_code(item.char_code);
      commit_b   = item.last_char && (pos_b < POS_LIMIT);
      // first character of a frame forgets which digits the last frame wrote
      shown_base = ((pos_ff == '0) && !held_valid_ff) ? '0 : shown_ff;
   end

   // next state
   always_comb begin
      codes_in      = codes_ff;
      shown_in      = shown_ff;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      held_code_in  = held_code_ff;
      held_valid_in = held_valid_ff;
      held_point_in = held_point_ff;
      if (fire) begin
         unique case (item.opcode)
            OP_TICK: begin
               scan_in = (scan_ff == SCAN_LAST) ? '0 : scan_ff + SCAN_W'(1);
            end
            OP_CHAR: begin
               shown_in = shown_base;
               // up to two digits land per word: the pushed-out one and, at
               // frame end, the one just formed
               for (int k = 0; k < NUM_DIGITS; k++) begin
                  if (commit_a && (pos_ff == POS_W'(k))) begin
                     codes_in[k] = held_code_ff;
                     shown_in[k] = 1'b1;
                  end
                  if (commit_b && (pos_b == POS_W'(k))) begin
                     codes_in[k] = new_code;
                     shown_in[k] = 1'b1;
                  end
               end
               if (item.last_char) begin
                  pos_in        = '0;
                  held_code_in  = BLANK_CODE;
                  held_valid_in = 1'b0;
                  held_point_in = 1'b0;
               end else begin
                  pos_in        = pos_b;
                  held_code_in  = new_code;
                  held_valid_in = 1'b1;
                  held_point_in = take_point;
               end
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_DIGITS; k++) begin
            codes_ff[k] <= 8'h00;
         end
         shown_ff      <= '1;
         scan_ff       <= '0;
         pos_ff        <= '0;
         held_code_ff  <= BLANK_CODE;
         held_valid_ff <= 1'b0;
         held_point_ff <= 1'b0;
      end else begin
         codes_ff      <= codes_in;
         shown_ff      <= shown_in;
         scan_ff       <= scan_in;
         pos_ff        <= pos_in;
         held_code_ff  <= held_code_in;
         held_valid_ff <= held_valid_in;
         held_point_ff <= held_point_in;
      end
   end

endmodule

/* rtl/ssd_out_reg.sv */
// result register: holds one result word until the sink takes it
// depends on: ssd_pkg
module ssd_out_reg import ssd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   output logic         out_free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata
);

   logic         valid_ff, valid_in;
   rsp_item_type data_ff, data_in;

   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   // next state, a load only comes while the register is free
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* rtl/seven_segment_text_scan_driver_core.sv */
// top level of the seven-segment text scan driver
// depends on: ssd_pkg, ssd_in_reg, ssd_engine, ssd_out_reg
//
//   channel | dir | tdata                          | tuser           | tlast
//   req_    | in  | [7:0] char_code                | opcode (1=tick) | last_char
//   rsp_    | out | [7:0] digit_select, [15:8] seg | -               | -
//
// one word per cycle sustained while no tick waits; an accepted tick reaches rsp
// valid through the input register, then the result register
// a character word never waits; a tick waits in the input register only while
// the result register is full and not being taken
// synchronous active-high reset; every digit then shows code 0x00 until the first character word
module seven_segment_text_scan_driver_core import ssd_pkg::*; #(
   parameter int NUM_DIGITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // [0] opcode
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] digit_select, [15:8] segment_code
);

   req_item_type req_item;
   req_item_type item;
   rsp_item_type result;
   logic         fire;
   logic         out_free;
   logic         load;

   // unpack the input word
   assign req_item = '{opcode: opcode_type'(req_tuser), char_code: req_tdata,
                       last_char: req_tlast};

   // only a tick produces a result
   assign load = fire && (item.opcode == OP_TICK);

   ssd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .out_free   (out_free),
      .fire       (fire),
      .item       (item)
   );

   ssd_engine #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   ssd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/ssd_checker.sv */
// port-level checks of the seven-segment text scan driver, bound to the top level
// depends on: seven_segment_text_scan_driver_core_macros.svh
`include "seven_segment_text_scan_driver_core_macros.svh"

module ssd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled result word holds
   `SSD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")

   // at most one digit is selected
   `SSD_ASSERT_SAME(a_sel_onehot, rsp_tvalid, $onehot0(rsp_tdata[7:0]), "digit select not one-hot")

   // the input side only stalls behind a full, stalled result register
   `SSD_ASSERT_SAME(a_req_stall, !req_tready, rsp_tvalid && !rsp_tready, "input stalled with room for a result")

   // a new result follows an accepted tick through the input register and the result register
   `SSD_ASSERT_SAME(a_rsp_from_tick, $rose(rsp_tvalid), $past(req_tvalid && req_tready && req_tuser, 2), "result without a tick")

endmodule

bind seven_segment_text_scan_driver_core ssd_checker u_checker (.*);

/* bench/segment_scan_checker.sv */
`timescale 1ns / 1ps
// checker for the seven-segment text scan driver: follows the display text and the
// scan ticks, predicts every scan word and compares it with the word the block returns
// depends on: ssd_pkg
module segment_scan_checker import ssd_pkg::*; #(
   parameter int NUM_DIGITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // [0] opcode
   input  logic        req_tlast,   // last_char
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] digit_select, [15:8] segment_code
   output int          fail_count,
   output int          outstanding
);

   // digit store of the frame and the character that may still take a point
   logic [7:0]            seg_store [NUM_DIGITS];
   logic [NUM_DIGITS-1:0] shown_mask;
   int unsigned           scan_pos;
   int unsigned           fill_pos;
   logic [7:0]            held_glyph;
   logic                  held_live;
   logic                  held_dotted;
   rsp_item_type          expected_scans [$];

   function automatic void note_fault(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("mismatch at %0t ns: %s", $time, msg);
      end
   endfunction

   // active-low segments of one ascii character
   function automatic logic [7:0] glyph_of(input logic [7:0] ch);
      logic [7:0] glyph;
      glyph = BLANK_CODE;
      if (ch >= "0" && ch <= "9") begin
         glyph = GLYPH_TABLE[ch - "0"];
      end else begin
         case (ch)
            "A": glyph = GLYPH_TABLE[10];
            "b": glyph = GLYPH_TABLE[11];
            "C": glyph = GLYPH_TABLE[12];
            "d": glyph = GLYPH_TABLE[13];
            "E": glyph = GLYPH_TABLE[14];
            "F": glyph = GLYPH_TABLE[15];
            "-": glyph = DASH_CODE;
            default: glyph = BLANK_CODE;
         endcase
      end
      return glyph;
   endfunction

   // move the held character into the next free digit, dropped once all are full
   function automatic void latch_held_digit();
      if (held_live && fill_pos < NUM_DIGITS) begin
         seg_store[fill_pos]  = held_glyph;
         shown_mask[fill_pos] = 1'b1;
         fill_pos++;
      end
      held_live   = 1'b0;
      held_dotted = 1'b0;
      held_glyph  = BLANK_CODE;
   endfunction

   function automatic void predict_char(input logic [7:0] ch, input logic frame_end);
      // first character of a frame hides every digit not yet rewritten
      if (fill_pos == 0 && !held_live) begin
         shown_mask = '0;
      end
      if (ch == DOT_CHAR && held_live && !held_dotted) begin
         held_glyph  = held_glyph & POINT_CLEAR;
         held_dotted = 1'b1;
      end else begin
         // a stray dot lands here too and becomes a blank digit
         latch_held_digit();
         held_glyph  = glyph_of(ch);
         held_live   = 1'b1;
         held_dotted = 1'b0;
      end
      if (frame_end) begin
         latch_held_digit();
         fill_pos = 0;
      end
   endfunction

   function automatic rsp_item_type predict_scan();
      rsp_item_type word;
      word.digit_select = (scan_pos < 8) ? 8'(1 << scan_pos) : 8'h00;
      word.segment_code = shown_mask[scan_pos] ? seg_store[scan_pos] : BLANK_CODE;
      scan_pos = (scan_pos + 1 >= NUM_DIGITS) ? 0 : scan_pos + 1;
      return word;
   endfunction

   // both channels sampled at the rising edge
   always @(posedge clock) begin
      rsp_item_type seen;
      rsp_item_type want;
      if (reset) begin
         foreach (seg_store[k]) seg_store[k] = 8'h00;
         shown_mask  = '1;
         scan_pos    = 0;
         fill_pos    = 0;
         held_glyph  = BLANK_CODE;
         held_live   = 1'b0;
         held_dotted = 1'b0;
         expected_scans.delete();
      end else begin
         // returned word against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_item_type'(rsp_tdata);
            if (expected_scans.size() == 0) begin
               note_fault($sformatf("scan word %h arrived with none predicted", rsp_tdata));
            end else begin
               want = expected_scans.pop_front();
               if (seen.digit_select !== want.digit_select) begin
                  note_fault($sformatf("digit_select expected %h, got %h",
                                       want.digit_select, seen.digit_select));
               end
               if (seen.segment_code !== want.segment_code) begin
                  note_fault($sformatf("segment_code expected %h, got %h",
                                       want.segment_code, seen.segment_code));
               end
            end
         end
         // accepted input word steps the prediction
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_TICK) begin
               expected_scans.push_back(predict_scan());
            end else begin
               predict_char(req_tdata, req_tlast);
            end
         end
      end
      outstanding = expected_scans.size();
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// top of the seven-segment text scan driver bench: clock, reset, text and tick stimulus,
// receiver stalls and the verdict
// depends on: ssd_pkg, seven_segment_text_scan_driver_core, segment_scan_checker
module testbench;
   import ssd_pkg::*;

   localparam int PHASE_WORDS = 425;
   localparam int SEND_IDLE [4]  = '{0, 57, 0, 23};
   localparam int RECV_STALL [4] = '{0, 0, 57, 23};
   localparam logic [7:0] TEXT_GLYPHS [17] = '{
      "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
      "A", "b", "C", "d", "E", "F", "-"
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   int          fail_count;
   int          outstanding;
   int          send_idle  = 0;
   int          recv_stall = 0;
   bit          random_started = 1'b0;

   seven_segment_text_scan_driver_core #(
      .NUM_DIGITS (8)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   segment_scan_checker #(
      .NUM_DIGITS (8)
   ) scan_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off early in the random part
   initial begin
      int hold_left;
      bit hold_done;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (random_started && !hold_done) begin
            hold_left = 64;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   // mostly glyphs and dots, the rest any byte at all
   function automatic logic [7:0] pick_char();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return TEXT_GLYPHS[$urandom_range(16)];
      if (roll < 65) return DOT_CHAR;
      return 8'($urandom_range(255));
   endfunction

   // offer one word after a random gap and hold it until taken
   task automatic send_item(input opcode_type op, input logic [7:0] ch, input logic lst);
      while ($urandom_range(99) < send_idle) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      int sent;
      int frame_len;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: scans before any text, a tick carrying last, dots and overflow
      send_item(OP_TICK, 8'h00, 1'b1);
      send_item(OP_TICK, 8'hff, 1'b0);
      send_item(OP_CHAR, "8", 1'b0);
      send_item(OP_CHAR, DOT_CHAR, 1'b0);
      send_item(OP_CHAR, DOT_CHAR, 1'b0);
      send_item(OP_CHAR, DOT_CHAR, 1'b0);
      send_item(OP_CHAR, 8'h00, 1'b0);
      send_item(OP_CHAR, "b", 1'b0);
      send_item(OP_CHAR, "F", 1'b0);
      send_item(OP_CHAR, "-", 1'b0);
      send_item(OP_CHAR, 8'hff, 1'b0);
      send_item(OP_CHAR, "9", 1'b0);
      send_item(OP_CHAR, "E", 1'b0);
      send_item(OP_CHAR, "d", 1'b1);
      repeat (8) send_item(OP_TICK, 8'h00, 1'b0);
      // short frame leaves the upper digits blank
      send_item(OP_CHAR, "C", 1'b0);
      send_item(OP_CHAR, "A", 1'b1);
      send_item(OP_TICK, DOT_CHAR, 1'b0);

      // random frames with ticks in between, one idling mix per phase
      for (int phase = 0; phase < 4; phase++) begin
         send_idle      = SEND_IDLE[phase];
         recv_stall     = RECV_STALL[phase];
         random_started = 1'b1;
         sent = 0;
         while (sent < PHASE_WORDS) begin
            frame_len = ($urandom_range(7) == 0) ? $urandom_range(9, 14)
                                                 : $urandom_range(1, 8);
            for (int k = 0; k < frame_len; k++) begin
               repeat ($urandom_range(2)) begin
                  send_item(OP_TICK, 8'($urandom), 1'($urandom));
                  sent++;
               end
               // now and then a frame runs on without its end mark
               send_item(OP_CHAR, pick_char(),
                         (k == frame_len - 1) && ($urandom_range(9) != 0));
               sent++;
            end
            repeat ($urandom_range(1, 4)) begin
               send_item(OP_TICK, 8'($urandom), 1'($urandom));
               sent++;
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
